// File: hdl/clahe_tile_map_interpolation_defines.svh
// assertion macros for the tile map interpolation block
// used by the top level only
`ifndef CLAHE_TILE_MAP_INTERPOLATION_DEFINES_SVH
`define CLAHE_TILE_MAP_INTERPOLATION_DEFINES_SVH
// implication checked at each clock edge outside reset
`define CTMI_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define CTMI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hdl/ctmi_pkg.sv
// shared constants and types for the tile map interpolation block
// no dependencies
`timescale 1ns / 1ps
package ctmi_pkg;
	localparam int TilesAcross = 8;
	localparam int TilesDown = 8;
	localparam int Bins = 256;
	localparam int TcW = $clog2(TilesAcross);
	localparam int TrW = $clog2(TilesDown);
	localparam int TileW = TcW + TrW;
	localparam int AddrW = TileW + 8;
	localparam int Depth = TilesAcross * TilesDown * Bins;
	localparam int NumStages = 7;
	localparam logic [1:0] RegTileWidth = 2'd0;
	localparam logic [1:0] RegTileHeight = 2'd1;
	localparam logic CmdWrite = 1'b0;
	localparam logic CmdPixel = 1'b1;
	// restoring divide of 2^34 by size+1, one quotient bit per cycle
	localparam logic [5:0] DivSteps = 6'd35;
	// quotient and remainder of 2^34 / 65 for the reset size of 64
	localparam logic [34:0] RecipQuoReset = 35'((64'd1 << 34) / 64'd65);
	localparam logic [9:0] RecipRemReset = 10'((64'd1 << 34) % 64'd65);

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} rgb_t;

	// per axis band result
	typedef struct packed {
		logic [11:0] off;   // pos - lower center, 0 in the low band
		logic [9:0] span;   // hi - lo + 1
		logic [3:0] t_lo;
		logic [3:0] t_hi;
	} band_t;
endpackage

// File: hdl/ctmi_ram.sv
// generic single write, single registered read port memory
// no dependencies
`timescale 1ns / 1ps
module ctmi_ram #(
	parameter int Width = 8,
	parameter int DepthP = 256
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DepthP)-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DepthP)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [DepthP];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// File: hdl/ctmi_band.sv
// finds band centers, tile indices and offset along one axis, two stages
// depends on ctmi_pkg
`timescale 1ns / 1ps
module ctmi_band import ctmi_pkg::*; (
	input  logic clk,
	input  logic en,
	input  logic [10:0] pos,
	input  logic [8:0] size,
	input  logic [4:0] count_m1,
	output band_t band
);
	// stage a: compare against band limits and parallel compare search of k
	logic [8:0] half;
	logic [15:0] last_start;
	logic [15:0] rel;
	logic [15:0] kb [16];
	logic [3:0] k;
	logic lo_band, hi_band;
	logic [3:0] k_q;
	logic lo_q, hi_q;
	logic [11:0] rel_q;
	logic [8:0] size_q;
	logic [3:0] cm1_q;
	logic [15:0] ksz;

	assign half = {1'b0, size[8:1]};
	assign last_start = 16'(count_m1) * 16'(size) + 16'(half);
	assign lo_band = {5'd0, pos} < {7'd0, half};
	assign hi_band = !lo_band && {5'd0, pos} >= last_start;
	assign rel = {5'd0, pos} - 16'(half);

	// k = rel / size, count below 16: largest k with k*size <= rel
	always_comb begin
		k = '0;
		for (int i = 0; i < 16; i++) begin
			kb[i] = 16'(i) * 16'(size);
			if (kb[i] <= rel && 5'(i) <= count_m1)
				k = 4'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			k_q <= k;
			lo_q <= lo_band;
			hi_q <= hi_band;
			rel_q <= rel[11:0];
			size_q <= size;
			cm1_q <= count_m1[3:0];
		end
	end

	assign ksz = 16'(k_q) * 16'(size_q);

	always_ff @(posedge clk) begin
		if (en) begin
			if (lo_q) begin
				band.off <= '0;
				band.span <= 10'd1;
				band.t_lo <= '0;
				band.t_hi <= '0;
			end else if (hi_q) begin
				band.off <= 12'(rel_q - 12'(cm1_q) * 12'(size_q));
				band.span <= 10'd1;
				band.t_lo <= cm1_q;
				band.t_hi <= cm1_q;
			end else begin
				band.off <= 12'(rel_q - ksz[11:0]);
				band.span <= 10'(size_q) + 10'd1;
				band.t_lo <= k_q;
				band.t_hi <= k_q + 4'd1;
			end
		end
	end
endmodule

// File: hdl/ctmi_blend.sv
// one channel: two horizontal lerps then one vertical lerp, two stages
// depends on ctmi_pkg
`timescale 1ns / 1ps
module ctmi_blend import ctmi_pkg::*; (
	input  logic clk,
	input  logic en,
	input  logic [16:0] fx,
	input  logic [16:0] fy,
	input  logic [7:0] ul,
	input  logic [7:0] ur,
	input  logic [7:0] dl,
	input  logic [7:0] dr,
	output logic [7:0] res
);
	logic signed [27:0] pa, pb, po;
	logic signed [9:0] a, b;
	logic signed [9:0] a_q, b_q;
	logic [16:0] fy_q;

	// products stay below 2^25 in magnitude, arithmetic shift gives floor
	assign pa = $signed({11'd0, fx}) * 28'(signed'({2'b0, ur} - {2'b0, ul}));
	assign pb = $signed({11'd0, fx}) * 28'(signed'({2'b0, dr} - {2'b0, dl}));
	assign a = signed'({2'b0, ul}) + 10'(pa >>> 16);
	assign b = signed'({2'b0, dl}) + 10'(pb >>> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			a_q <= a;
			b_q <= b;
			fy_q <= fy;
		end
	end

	assign po = $signed({11'd0, fy_q}) * 28'(b_q - a_q);

	always_ff @(posedge clk) begin
		if (en)
			res <= 8'(a_q + 10'(po >>> 16));
	end
endmodule

// File: hdl/clahe_tile_map_interpolation.sv
// top level of the clahe tile map interpolation stage
// depends on ctmi_pkg, ctmi_band, ctmi_blend, ctmi_ram and the defines header
//
// channel   dir  kind     content
// s_axis    in   stream   cmd, map write fields, pixel position, rgb
// m_axis    out  stream   interpolated rgb
// apb       in   config   tile_width at 0x0, tile_height at 0x4
//
// one item per cycle while no output stall or size rebuild holds the input; seven
// register stages, the first loaded at the accepting edge
// stages: band search, band fix, weight operands, weights (reciprocal multiply),
// map read (twelve ram copies), horizontal lerp, vertical lerp
// the whole pipe holds on a stall of the output; reset clears valids and sets sizes
// to 64 with their reciprocals; a size write holds the input while 2^34/(size+1) is rebuilt
// map writes ride the pipe and land in the map read stage, in order with reads
`timescale 1ns / 1ps
`include "clahe_tile_map_interpolation_defines.svh"
module clahe_tile_map_interpolation import ctmi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// map_tile_row[2:0], map_tile_col[5:3], map_bin[13:6], map_value[21:14],
	// pixel_x[32:22], pixel_y[43:33], red_in[51:44], green_in[59:52], blue_in[67:60]
	input  logic [71:0] s_axis_tdata,
	input  logic s_axis_tuser,      // cmd
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [23:0] m_axis_tdata, // red_out[7:0], green_out[15:8], blue_out[23:16]
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [8:0] tile_width_q, tile_height_q;
	logic en;
	logic [NumStages-1:0] vld_q;
	logic acc;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q <= 9'd64;
			tile_height_q <= 9'd64;
		end else if (cfg_wr) begin
			if (paddr[2] == RegTileHeight[0])
				tile_height_q <= pwdata[8:0];
			else
				tile_width_q <= pwdata[8:0];
		end
	end
	assign prdata = paddr[2] ? {23'd0, tile_height_q} : {23'd0, tile_width_q};

	// ceil(2^34 / (size+1)) per axis, index 0 for x, 1 for y
	logic [9:0] dvs_q [2];
	logic [34:0] quo_q [2];
	logic [9:0] rem_q [2];
	logic [5:0] cnt_q [2];
	logic [10:0] sh [2];
	logic [33:0] recip [2];
	logic busy;

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			sh[a] = {rem_q[a], cnt_q[a] == DivSteps};
			recip[a] = 34'(quo_q[a] + 35'(rem_q[a] != '0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 2; a++) begin
				dvs_q[a] <= 10'd65;
				quo_q[a] <= RecipQuoReset;
				rem_q[a] <= RecipRemReset;
				cnt_q[a] <= '0;
			end
		end else begin
			for (int a = 0; a < 2; a++) begin
				if (cfg_wr && paddr[2] == 1'(a)) begin
					dvs_q[a] <= 10'(pwdata[8:0]) + 10'd1;
					quo_q[a] <= '0;
					rem_q[a] <= '0;
					cnt_q[a] <= DivSteps;
				end else if (cnt_q[a] != '0) begin
					if (sh[a] >= {1'b0, dvs_q[a]}) begin
						rem_q[a] <= 10'(sh[a] - {1'b0, dvs_q[a]});
						quo_q[a] <= {quo_q[a][33:0], 1'b1};
					end else begin
						rem_q[a] <= sh[a][9:0];
						quo_q[a] <= {quo_q[a][33:0], 1'b0};
					end
					cnt_q[a] <= cnt_q[a] - 6'd1;
				end
			end
		end
	end
	assign busy = (cnt_q[0] != '0) || (cnt_q[1] != '0);

	// whole pipe advances unless the output holds a beat not taken
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en && !busy;
	assign acc = s_axis_tvalid && s_axis_tready;

	// map writes
	logic [2:0] w_row, w_col;
	logic [7:0] w_bin, w_val;
	logic wr_in;
	logic we;
	logic [10:0] px, py;
	rgb_t pix_in;
	assign w_row = s_axis_tdata[2:0];
	assign w_col = s_axis_tdata[5:3];
	assign w_bin = s_axis_tdata[13:6];
	assign w_val = s_axis_tdata[21:14];
	assign px = s_axis_tdata[32:22];
	assign py = s_axis_tdata[43:33];
	assign pix_in = {s_axis_tdata[67:60], s_axis_tdata[59:52], s_axis_tdata[51:44]};
	assign wr_in = acc && s_axis_tuser == CmdWrite
		&& 32'(w_row) < TilesDown && 32'(w_col) < TilesAcross;

	// write beats travel with the pipe, address then value
	logic wv_s1, wv_s2, wv_s3, wv_s4;
	logic [AddrW+7:0] wr_s1, wr_s2, wr_s3, wr_s4;

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wv_s1 <= 1'b0;
			wv_s2 <= 1'b0;
			wv_s3 <= 1'b0;
			wv_s4 <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[NumStages-2:0], acc && s_axis_tuser == CmdPixel};
			wv_s1 <= wr_in;
			wv_s2 <= wv_s1;
			wv_s3 <= wv_s2;
			wv_s4 <= wv_s3;
		end
	end
	assign m_axis_tvalid = vld_q[NumStages-1];

	always_ff @(posedge clk) begin
		if (en) begin
			wr_s1 <= {w_row[TrW-1:0], w_col[TcW-1:0], w_bin, w_val};
			wr_s2 <= wr_s1;
			wr_s3 <= wr_s2;
			wr_s4 <= wr_s3;
		end
	end
	assign we = wv_s4 && en;

	// stages 1-2: bands
	band_t bx, by;
	ctmi_band u_bx (.clk, .en, .pos(px), .size(tile_width_q),
		.count_m1(5'(TilesAcross - 1)), .band(bx));
	ctmi_band u_by (.clk, .en, .pos(py), .size(tile_height_q),
		.count_m1(5'(TilesDown - 1)), .band(by));

	rgb_t pix_s1, pix_s2, pix_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			pix_s1 <= pix_in;
			pix_s2 <= pix_s1;
			pix_s3 <= pix_s2;
		end
	end

	// stage 3: weight operands; offsets only matter in the middle band, below 512
	logic [16:0] recip_s3;
	logic [8:0] offx_s3;
	logic [8:0] offy_s3;
	band_t bx_s3, by_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			recip_s3 <= {1'b0, recip[0][33:18]};
			offx_s3 <= bx.off[8:0];
			offy_s3 <= by.off[8:0];
			bx_s3 <= bx;
			by_s3 <= by;
		end
	end

	// stage 4: weights; fx = off*floor(65536/span), fy = off*65536/span by reciprocal
	// at the edge bands both taps are the same tile so the weight drops out
	logic [16:0] fx_s4, fy_s4;
	logic [42:0] fy_prod;
	assign fy_prod = 43'(offy_s3) * 43'(recip[1]);
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s4 <= 17'(offx_s3 * recip_s3);
			fy_s4 <= fy_prod[34:18];
		end
	end

	// stage 4 also issues map reads, stage 5 gets data
	logic [TileW-1:0] t_ul, t_ur, t_dl, t_dr;
	assign t_ul = {by_s3.t_lo[TrW-1:0], bx_s3.t_lo[TcW-1:0]};
	assign t_ur = {by_s3.t_lo[TrW-1:0], bx_s3.t_hi[TcW-1:0]};
	assign t_dl = {by_s3.t_hi[TrW-1:0], bx_s3.t_lo[TcW-1:0]};
	assign t_dr = {by_s3.t_hi[TrW-1:0], bx_s3.t_hi[TcW-1:0]};
	logic [TileW-1:0] tsel [4];
	assign tsel[0] = t_ul;
	assign tsel[1] = t_ur;
	assign tsel[2] = t_dl;
	assign tsel[3] = t_dr;
	logic [7:0] chv [3];
	assign chv[0] = pix_s3.red;
	assign chv[1] = pix_s3.green;
	assign chv[2] = pix_s3.blue;

	logic [7:0] rd [3][4];
	logic [16:0] fx_s5, fy_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			fx_s5 <= fx_s4;
			fy_s5 <= fy_s4;
		end
	end
	// reads one stage late: address registered with the weights
	logic [TileW-1:0] tsel_s4 [4];
	logic [7:0] chv_s4 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			tsel_s4 <= tsel;
			chv_s4 <= chv;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_ch
		for (genvar q = 0; q < 4; q++) begin : g_q
			ctmi_ram #(.Width(8), .DepthP(Depth)) u_ram (
				.clk,
				.we,
				.waddr(wr_s4[AddrW+7:8]),
				.wdata(wr_s4[7:0]),
				.re(en),
				.raddr({tsel_s4[q], chv_s4[c]}),
				.rdata(rd[c][q])
			);
		end
		ctmi_blend u_bl (.clk, .en, .fx(fx_s5), .fy(fy_s5),
			.ul(rd[c][0]), .ur(rd[c][1]), .dl(rd[c][2]), .dr(rd[c][3]),
			.res(m_axis_tdata[8*c +: 8]));
	end

	`CTMI_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "beat dropped")
	`CTMI_ASSERT_IMPL(a_ready, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "accept on stall")
endmodule

// File: test/testbench.sv
// self-checking bench for the clahe tile map interpolation stage
// drives map writes and pixels on the input stream and checks interpolated rgb beats
// depends on ctmi_pkg and the clahe_tile_map_interpolation top level
`timescale 1ns / 1ps
module testbench;
	import ctmi_pkg::*;

	typedef struct packed {
		logic       cmd;
		logic [2:0] trow;
		logic [2:0] tcol;
		logic [7:0] bin;
		logic [7:0] value;
		logic [10:0] px;
		logic [10:0] py;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} beat_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [71:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;

	clahe_tile_map_interpolation dut (.*);

	beat_t pending[$];
	rgb_t expected_rgb[$];
	logic [7:0] map_mirror [0:Depth-1];
	int unsigned width_now, height_now;
	int errors;
	bit quiet_phase, hold_off_req, hold_off_on, pause_req;
	int unsigned send_gap, recv_gap, idle_cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// one axis: lower center offset, span and tile indices
	function automatic void band(input int pos, input int size, input int count,
		output int off, output int span, output int tlo, output int thi);
		int half, last_start, k;
		half = size / 2;
		last_start = (count - 1) * size + half;
		if (pos < half) begin
			off = pos - half; span = 1; tlo = 0; thi = 0;
		end else if (pos >= last_start) begin
			off = pos - last_start; span = 1; tlo = count - 1; thi = count - 1;
		end else begin
			k = (pos - half) / size;
			off = pos - (k * size + half); span = size + 1; tlo = k; thi = k + 1;
		end
	endfunction

	function automatic longint floor16(input longint v);
		return v >>> 16;
	endfunction

	function automatic rgb_t interpolate(input beat_t it);
		int ox, oy, sx, sy, tl, tr, tu, td;
		longint fx, fy, ul, ur, dl, dr, a, b, o;
		logic [7:0] ch[3];
		logic [7:0] res[3];
		rgb_t out;
		band(it.py, height_now, TilesDown, oy, sy, tu, td);
		band(it.px, width_now, TilesAcross, ox, sx, tl, tr);
		fy = (longint'(oy) * 65536) / sy;
		fx = longint'(ox) * (65536 / sx);
		ch[0] = it.r; ch[1] = it.g; ch[2] = it.b;
		for (int c = 0; c < 3; c++) begin
			ul = map_mirror[(tu * TilesAcross + tl) * Bins + ch[c]];
			ur = map_mirror[(tu * TilesAcross + tr) * Bins + ch[c]];
			dl = map_mirror[(td * TilesAcross + tl) * Bins + ch[c]];
			dr = map_mirror[(td * TilesAcross + tr) * Bins + ch[c]];
			a = ul + floor16(fx * (ur - ul));
			b = dl + floor16(fx * (dr - dl));
			o = a + floor16(fy * (b - a));
			res[c] = o[7:0];
		end
		out.red = res[0]; out.green = res[1]; out.blue = res[2];
		return out;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0; s_axis_tdata <= '0; s_axis_tuser <= 0; send_gap <= 0;
		end else begin
			beat_t it;
			if (s_axis_tvalid && s_axis_tready) begin
				it = pending.pop_front();
				if (it.cmd == CmdWrite)
					map_mirror[(it.trow * TilesAcross + it.tcol) * Bins + it.bin] = it.value;
				else
					expected_rgb.push_back(interpolate(it));
			end
			if (s_axis_tvalid && !s_axis_tready) begin
			end else if (send_gap != 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 0;
			end else if (pending.size() != 0 && !pause_req
				&& !(s_axis_tvalid && s_axis_tready && pending.size() == 0)) begin
				if (!quiet_phase && $urandom_range(0, 15) == 0) begin
					send_gap <= $urandom_range(0, 12);
					s_axis_tvalid <= 0;
				end else begin
					it = pending[0];
					s_axis_tvalid <= 1;
					s_axis_tuser <= it.cmd;
					s_axis_tdata <= {4'b0, it.b, it.g, it.r, it.py, it.px,
						it.value, it.bin, it.tcol, it.trow};
				end
			end else
				s_axis_tvalid <= 0;
		end
	end

	// monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0; recv_gap <= 0; hold_off_on <= 0;
		end else begin
			rgb_t got, want;
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (expected_rgb.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					want = expected_rgb.pop_front();
					if (got.red !== want.red) begin
						$error("red_out expected %0d got %0d", want.red, got.red); errors++;
					end
					if (got.green !== want.green) begin
						$error("green_out expected %0d got %0d", want.green, got.green);
						errors++;
					end
					if (got.blue !== want.blue) begin
						$error("blue_out expected %0d got %0d", want.blue, got.blue); errors++;
					end
				end
			end
			if (hold_off_req && !hold_off_on) begin
				hold_off_on <= 1; recv_gap <= 200; m_axis_tready <= 0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1; m_axis_tready <= 0;
				if (recv_gap == 1) hold_off_on <= 0;
			end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
				recv_gap <= $urandom_range(0, 12); m_axis_tready <= 0;
			end else
				m_axis_tready <= 1;
		end
	end

	// watchdog on accepted beats
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| pending.size() == 0 && expected_rgb.size() == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr == 3'd0) width_now = data[8:0];
		else height_now = data[8:0];
	endtask

	task automatic drain();
		while (pending.size() != 0 || expected_rgb.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// pixels only use these bins, all of which are loaded in every tile
	function automatic int bin_of(input int j);
		return j * 255 / 7;
	endfunction

	function automatic beat_t map_write(input int tr, input int tc, input int bn, input int v);
		beat_t it;
		it = '0;
		it.cmd = CmdWrite; it.trow = 3'(tr); it.tcol = 3'(tc); it.bin = 8'(bn);
		it.value = 8'(v);
		return it;
	endfunction

	function automatic beat_t pixel(input int x, input int y);
		beat_t it;
		it = '0;
		it.cmd = CmdPixel; it.px = 11'(x); it.py = 11'(y);
		it.r = 8'(bin_of($urandom_range(0, 7)));
		it.g = 8'(bin_of($urandom_range(0, 7)));
		it.b = 8'(bin_of($urandom_range(0, 7)));
		return it;
	endfunction

	// load the pixel bins of every tile with random content
	task automatic fill_maps();
		for (int t = 0; t < TilesDown * TilesAcross; t++)
			for (int j = 0; j < 8; j++)
				pending.push_back(map_write(t / TilesAcross, t % TilesAcross, bin_of(j),
					$urandom_range(0, 255)));
		drain();
	endtask

	initial begin
		int sizes[6] = '{64, 2, 256, 3, 37, 100};
		arst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		errors = 0; quiet_phase = 0; hold_off_req = 0; pause_req = 0;
		width_now = 64; height_now = 64;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		fill_maps();
		// directed: extremes and map write edge values
		pending.push_back(map_write(7, 7, 255, 255));
		pending.push_back(map_write(0, 0, 0, 0));
		pending.push_back(pixel(0, 0));
		pending.push_back(pixel(2047, 2047));
		pending.push_back(pixel(31, 32));
		pending.push_back(pixel(32, 31));
		pending.push_back(pixel(479, 480));
		pending.push_back(pixel(480, 479));
		pending.push_back(pixel(100, 1000));
		pending.push_back(pixel(1365, 682));
		drain();
		for (int s = 0; s < 6; s++) begin
			apb_write(3'd0, sizes[s]);
			apb_write(3'd4, sizes[(s + 2) % 6]);
			if (s == 1) hold_off_req = 1;
			for (int n = 0; n < 210; n++) begin
				if ($urandom_range(0, 5) == 0)
					pending.push_back(map_write($urandom_range(0, 7), $urandom_range(0, 7),
						$urandom_range(0, 255), $urandom_range(0, 255)));
				else if ($urandom_range(0, 3) == 0)
					pending.push_back(pixel($urandom_range(0, 2047), $urandom_range(0, 2047)));
				else
					pending.push_back(pixel($urandom_range(0, 8 * sizes[s] + 2),
						$urandom_range(0, 8 * sizes[(s + 2) % 6] + 2)));
				if (n == 100 && s == 3) begin
					while (pending.size() > 20) @(posedge clk);
					pause_req = 1;
					while (expected_rgb.size() != 0) @(posedge clk);
					repeat (5) @(posedge clk);
					pause_req = 0;
				end
			end
			if (s == 1) begin
				wait (hold_off_on);
				hold_off_req = 0;
			end
			if (s == 5) quiet_phase = 1;
			drain();
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
